// ===== design/shcl_pkg.sv =====
`timescale 1ns / 1ps

package shcl_pkg;

  localparam int unsigned MaxResults = 4;

  // Result kinds, carried on the output tuser.
  localparam logic [1:0] KIND_BYTE = 2'd0;
  localparam logic [1:0] KIND_WEND = 2'd1;
  localparam logic [1:0] KIND_OP   = 2'd2;
  localparam logic [1:0] KIND_LEND = 2'd3;

  // Operator codes.
  localparam logic [2:0] OP_AMP   = 3'd0;
  localparam logic [2:0] OP_GT    = 3'd1;
  localparam logic [2:0] OP_GTGT  = 3'd2;
  localparam logic [2:0] OP_1GT   = 3'd3;
  localparam logic [2:0] OP_1GTGT = 3'd4;
  localparam logic [2:0] OP_2GT   = 3'd5;
  localparam logic [2:0] OP_2GTGT = 3'd6;

  // Held operator prefixes.
  localparam logic [2:0] PEND_NONE = 3'd0;
  localparam logic [2:0] PEND_1    = 3'd1;
  localparam logic [2:0] PEND_2    = 3'd2;
  localparam logic [2:0] PEND_GT   = 3'd3;
  localparam logic [2:0] PEND_1GT  = 3'd4;
  localparam logic [2:0] PEND_2GT  = 3'd5;

  // Characters with a meaning to the lexer.
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_TWO    = 8'h32;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] word_byte;
    logic [2:0] op;
  } res_t;

endpackage

// ===== design/shell_command_line_lexer.sv =====
`timescale 1ns / 1ps

// The first result of a character is presented in the cycle after its transaction.
// Throughput: one character per cycle while each yields at most one result and the output
// is not stalled; a character yielding several results holds the input until its final
// result is leaving, set by the single result port.
// Reset (rst_ni low, asynchronous) clears the quote, escape, open-word and held-operator
// state and empties the result buffer.
module shell_command_line_lexer
  import shcl_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
  input  logic        s_axis_tlast,   // line_end
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] word_byte, [10:8] operator_code, rest zero
  output logic [1:0]  m_axis_tuser,   // [1:0] item_kind
  output logic        m_axis_tlast    // run_last
);

  logic       sq_q, sq_d;
  logic       dq_q, dq_d;
  logic       esc_q, esc_d;
  logic       wo_q, wo_d;
  logic [2:0] pend_q, pend_d;

  res_t       res_q [MaxResults];
  res_t       res_n [MaxResults];
  logic [2:0] cnt_n;
  logic [2:0] rem_q, rem_d;
  logic [1:0] rd_q, rd_d;

  logic in_acc, out_acc;

  assign m_axis_tvalid = (rem_q != 3'd0);
  assign m_axis_tlast  = (rem_q == 3'd1);
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  // A new character may enter while the final result of the previous one leaves.
  assign s_axis_tready = (rem_q == 3'd0) || (rem_q == 3'd1 && m_axis_tready);
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  assign m_axis_tuser  = res_q[rd_q].kind;
  assign m_axis_tdata  = {5'd0, res_q[rd_q].op, res_q[rd_q].word_byte};

  // Lexing of one character: results are collected in order into res_n.
  always_comb begin
    logic [7:0] c;
    logic       last;
    logic       do_plain;
    logic       quoted;
    logic [2:0] base;
    c        = s_axis_tdata;
    last     = s_axis_tlast;
    do_plain = 1'b0;
    quoted   = 1'b0;
    base     = OP_GT;
    sq_d     = sq_q;
    dq_d     = dq_q;
    esc_d    = esc_q;
    wo_d     = wo_q;
    pend_d   = pend_q;
    cnt_n    = 3'd0;
    for (int i = 0; i < MaxResults; i++) begin
      res_n[i] = '0;
    end

    if (esc_q) begin
      esc_d = 1'b0;
      res_n[cnt_n[1:0]] = '{kind: KIND_BYTE, word_byte: c, op: 3'd0};
      cnt_n = cnt_n + 3'd1;
      wo_d  = 1'b1;
    end else begin
      pend_d = PEND_NONE;
      unique case (pend_q)
        PEND_1, PEND_2: begin
          if (c == CH_GT) begin
            if (wo_d) begin
              res_n[cnt_n[1:0]] = '{kind: KIND_WEND, word_byte: 8'd0, op: 3'd0};
              cnt_n = cnt_n + 3'd1;
              wo_d  = 1'b0;
            end
            if (last) begin
              res_n[cnt_n[1:0]] = '{kind: KIND_OP, word_byte: 8'd0,
                                    op: (pend_q == PEND_1) ? OP_1GT : OP_2GT};
              cnt_n = cnt_n + 3'd1;
            end else begin
              pend_d = (pend_q == PEND_1) ? PEND_1GT : PEND_2GT;
            end
          end else begin
            res_n[cnt_n[1:0]] = '{kind: KIND_BYTE,
                                  word_byte: (pend_q == PEND_1) ? CH_ONE : CH_TWO,
                                  op: 3'd0};
            cnt_n    = cnt_n + 3'd1;
            wo_d     = 1'b1;
            do_plain = 1'b1;
          end
        end
        PEND_GT, PEND_1GT, PEND_2GT: begin
          base = (pend_q == PEND_GT) ? OP_GT : (pend_q == PEND_1GT) ? OP_1GT : OP_2GT;
          if (c == CH_GT) begin
            // The second '>' doubles the operator and is consumed by it.
            res_n[cnt_n[1:0]] = '{kind: KIND_OP, word_byte: 8'd0, op: base + 3'd1};
            cnt_n = cnt_n + 3'd1;
          end else begin
            res_n[cnt_n[1:0]] = '{kind: KIND_OP, word_byte: 8'd0, op: base};
            cnt_n    = cnt_n + 3'd1;
            do_plain = 1'b1;
          end
        end
        default: do_plain = 1'b1;
      endcase
    end

    if (do_plain) begin
      quoted = sq_q || dq_q;
      priority if (!sq_q && c == CH_BSLASH && !last) begin
        esc_d = 1'b1;
      end else if (c == CH_SQUOTE && !dq_q) begin
        sq_d = ~sq_q;
      end else if (c == CH_DQUOTE && !sq_q) begin
        dq_d = ~dq_q;
      end else if (quoted) begin
        res_n[cnt_n[1:0]] = '{kind: KIND_BYTE, word_byte: c, op: 3'd0};
        cnt_n = cnt_n + 3'd1;
        wo_d  = 1'b1;
      end else if (c == CH_SPACE || c == CH_AMP || c == CH_GT) begin
        if (wo_d) begin
          res_n[cnt_n[1:0]] = '{kind: KIND_WEND, word_byte: 8'd0, op: 3'd0};
          cnt_n = cnt_n + 3'd1;
          wo_d  = 1'b0;
        end
        if (c == CH_AMP) begin
          res_n[cnt_n[1:0]] = '{kind: KIND_OP, word_byte: 8'd0, op: OP_AMP};
          cnt_n = cnt_n + 3'd1;
        end else if (c == CH_GT) begin
          if (last) begin
            res_n[cnt_n[1:0]] = '{kind: KIND_OP, word_byte: 8'd0, op: OP_GT};
            cnt_n = cnt_n + 3'd1;
          end else begin
            pend_d = PEND_GT;
          end
        end
      end else if ((c == CH_ONE || c == CH_TWO) && !last) begin
        pend_d = (c == CH_ONE) ? PEND_1 : PEND_2;
      end else begin
        res_n[cnt_n[1:0]] = '{kind: KIND_BYTE, word_byte: c, op: 3'd0};
        cnt_n = cnt_n + 3'd1;
        wo_d  = 1'b1;
      end
    end

    if (last) begin
      if (wo_d) begin
        res_n[cnt_n[1:0]] = '{kind: KIND_WEND, word_byte: 8'd0, op: 3'd0};
        cnt_n = cnt_n + 3'd1;
      end
      res_n[cnt_n[1:0]] = '{kind: KIND_LEND, word_byte: 8'd0, op: 3'd0};
      cnt_n  = cnt_n + 3'd1;
      sq_d   = 1'b0;
      dq_d   = 1'b0;
      esc_d  = 1'b0;
      wo_d   = 1'b0;
      pend_d = PEND_NONE;
    end
  end

  always_comb begin
    rem_d = rem_q;
    rd_d  = rd_q;
    if (in_acc) begin
      rem_d = cnt_n;
      rd_d  = 2'd0;
    end else if (out_acc) begin
      rem_d = rem_q - 3'd1;
      rd_d  = rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_q   <= 1'b0;
      dq_q   <= 1'b0;
      esc_q  <= 1'b0;
      wo_q   <= 1'b0;
      pend_q <= PEND_NONE;
      rem_q  <= 3'd0;
      rd_q   <= 2'd0;
    end else begin
      rem_q <= rem_d;
      rd_q  <= rd_d;
      if (in_acc) begin
        sq_q   <= sq_d;
        dq_q   <= dq_d;
        esc_q  <= esc_d;
        wo_q   <= wo_d;
        pend_q <= pend_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      for (int i = 0; i < MaxResults; i++) begin
        res_q[i] <= res_n[i];
      end
    end
  end

endmodule

// ===== verif/shell_command_line_lexer_tb.sv =====
`timescale 1ns / 1ps

module shell_command_line_lexer_tb;
  import shcl_pkg::*;

  localparam int RandItems = 400;
  localparam int CalmItems = 60;
  localparam int DirLen    = 25;

  typedef struct packed {
    res_t r;
    logic last;
  } tok_t;

  // One directed character; n > 0 means the first n results are typed in below.
  typedef struct packed {
    logic [7:0] ch;
    logic       eol;
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
    res_t       r2;
  } row_t;

  localparam res_t RES_NONE = '0;
  localparam res_t RES_WEND = '{KIND_WEND, 8'h00, 3'd0};
  localparam res_t RES_LEND = '{KIND_LEND, 8'h00, 3'd0};
  localparam res_t RES_AMP  = '{KIND_OP, 8'h00, OP_AMP};
  localparam res_t RES_GT   = '{KIND_OP, 8'h00, OP_GT};
  localparam res_t RES_GTGT = '{KIND_OP, 8'h00, OP_GTGT};
  localparam res_t RES_B00  = '{KIND_BYTE, 8'h00, 3'd0};
  localparam res_t RES_BFF  = '{KIND_BYTE, 8'hFF, 3'd0};

  row_t dir_tab [DirLen] = '{
    '{CH_SPACE,  1'b1, 2'd1, RES_LEND, RES_NONE, RES_NONE},
    '{8'h00,     1'b1, 2'd3, RES_B00,  RES_WEND, RES_LEND},
    '{8'hFF,     1'b1, 2'd3, RES_BFF,  RES_WEND, RES_LEND},
    '{CH_AMP,    1'b1, 2'd2, RES_AMP,  RES_LEND, RES_NONE},
    '{CH_GT,     1'b1, 2'd2, RES_GT,   RES_LEND, RES_NONE},
    '{CH_ONE,    1'b0, 2'd0, RES_NONE, RES_NONE, RES_NONE},
    '{CH_GT,     1'b0, 2'd0, RES_NONE, RES_NONE, RES_NONE},
    '{CH_GT,     1'b0, 2'd0, RES_NONE, RES_NONE, RES_NONE},
    '{8'h78,     1'b1, 2'd0, RES_NONE, RES_NONE, RES_NONE},
    '{8'h61,     1'b0, 2'd0, RES_NONE, RES_NONE, RES_NONE},
    '{CH_TWO,    1'b0, 2'd0, RES_NONE, RES_NONE, RES_NONE},
    '{CH_GT,     1'b0, 2'd0, RES_NONE, RES_NONE, RES_NONE},
    '{8'h62,     1'b1, 2'd0, RES_NONE, RES_NONE, RES_NONE},
    '{CH_GT,     1'b0, 2'd0, RES_NONE, RES_NONE, RES_NONE},
    '{CH_GT,     1'b1, 2'd2, RES_GTGT, RES_LEND, RES_NONE},
    '{CH_SQUOTE, 1'b0, 2'd0, RES_NONE, RES_NONE, RES_NONE},
    '{CH_BSLASH, 1'b0, 2'd0, RES_NONE, RES_NONE, RES_NONE},
    '{CH_SQUOTE, 1'b0, 2'd0, RES_NONE, RES_NONE, RES_NONE},
    '{CH_DQUOTE, 1'b0, 2'd0, RES_NONE, RES_NONE, RES_NONE},
    '{CH_BSLASH, 1'b0, 2'd0, RES_NONE, RES_NONE, RES_NONE},
    '{CH_DQUOTE, 1'b0, 2'd0, RES_NONE, RES_NONE, RES_NONE},
    '{CH_DQUOTE, 1'b0, 2'd0, RES_NONE, RES_NONE, RES_NONE},
    '{CH_BSLASH, 1'b1, 2'd0, RES_NONE, RES_NONE, RES_NONE},
    '{CH_DQUOTE, 1'b0, 2'd0, RES_NONE, RES_NONE, RES_NONE},
    '{CH_DQUOTE, 1'b1, 2'd1, RES_LEND, RES_NONE, RES_NONE}
  };

  logic [7:0] special_chars [8] = '{
    CH_BSLASH, CH_SQUOTE, CH_DQUOTE, CH_SPACE, CH_AMP, CH_GT, CH_ONE, CH_TWO
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;   // [7:0] char_in
  logic        s_axis_tlast;   // line_end
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;   // [7:0] word_byte, [10:8] operator_code, rest zero
  logic [1:0]  m_axis_tuser;   // [1:0] item_kind
  logic        m_axis_tlast;   // run_last

  // Lexer state as predicted.
  logic       in_squote;
  logic       in_dquote;
  logic       esc_next;
  logic       word_open;
  logic [2:0] held_op;

  tok_t tok_step_q [$];
  tok_t tok_q [$];
  int   n_err;
  bit   idle_on;

  shell_command_line_lexer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  task automatic add_tok(input logic [1:0] kind, input logic [7:0] b, input logic [2:0] op);
    tok_t t;
    t.r.kind      = kind;
    t.r.word_byte = b;
    t.r.op        = op;
    t.last        = 1'b0;
    tok_step_q    = {tok_step_q, t};
  endtask

  task automatic add_word_byte(input logic [7:0] b);
    add_tok(KIND_BYTE, b, 3'd0);
    word_open = 1'b1;
  endtask

  task automatic close_word();
    if (word_open) begin
      add_tok(KIND_WEND, 8'h00, 3'd0);
      word_open = 1'b0;
    end
  endtask

  // A character seen with no escape in force and no operator held.
  task automatic lex_plain(input logic [7:0] c, input logic eol);
    logic quoted;
    quoted = in_squote || in_dquote;
    if (!in_squote && c == CH_BSLASH && !eol) begin
      esc_next = 1'b1;
    end else if (c == CH_SQUOTE && !in_dquote) begin
      in_squote = ~in_squote;
    end else if (c == CH_DQUOTE && !in_squote) begin
      in_dquote = ~in_dquote;
    end else if (quoted) begin
      add_word_byte(c);
    end else if (c == CH_SPACE) begin
      close_word();
    end else if (c == CH_AMP) begin
      close_word();
      add_tok(KIND_OP, 8'h00, OP_AMP);
    end else if (c == CH_GT) begin
      close_word();
      if (eol) add_tok(KIND_OP, 8'h00, OP_GT);
      else held_op = PEND_GT;
    end else if ((c == CH_ONE || c == CH_TWO) && !eol) begin
      held_op = (c == CH_ONE) ? PEND_1 : PEND_2;
    end else begin
      add_word_byte(c);
    end
  endtask

  // Fills tok_step_q with the tokens one character produces.
  task automatic lex_char(input logic [7:0] c, input logic eol);
    logic [2:0] p;
    p = held_op;
    tok_step_q.delete();
    if (esc_next) begin
      esc_next = 1'b0;
      add_word_byte(c);
    end else if (p == PEND_1 || p == PEND_2) begin
      held_op = PEND_NONE;
      if (c == CH_GT) begin
        close_word();
        if (eol) add_tok(KIND_OP, 8'h00, (p == PEND_1) ? OP_1GT : OP_2GT);
        else held_op = (p == PEND_1) ? PEND_1GT : PEND_2GT;
      end else begin
        add_word_byte((p == PEND_1) ? CH_ONE : CH_TWO);
        lex_plain(c, eol);
      end
    end else if (p == PEND_GT || p == PEND_1GT || p == PEND_2GT) begin
      held_op = PEND_NONE;
      if (c == CH_GT) begin
        add_tok(KIND_OP, 8'h00,
                (p == PEND_GT) ? OP_GTGT : (p == PEND_1GT) ? OP_1GTGT : OP_2GTGT);
      end else begin
        add_tok(KIND_OP, 8'h00, (p == PEND_GT) ? OP_GT : (p == PEND_1GT) ? OP_1GT : OP_2GT);
        lex_plain(c, eol);
      end
    end else begin
      held_op = PEND_NONE;
      lex_plain(c, eol);
    end
    if (eol) begin
      close_word();
      add_tok(KIND_LEND, 8'h00, 3'd0);
      in_squote = 1'b0;
      in_dquote = 1'b0;
      esc_next  = 1'b0;
      word_open = 1'b0;
      held_op   = PEND_NONE;
    end
  endtask

  // Called at a falling edge; returns at the falling edge after the transaction.
  task automatic put_char(input logic [7:0] c, input logic eol, input logic [1:0] n,
                          input res_t r0, input res_t r1, input res_t r2);
    tok_t t;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    s_axis_tlast  <= eol;
    do @(posedge clk_i); while (!s_axis_tready);
    lex_char(c, eol);
    if (n != 2'd0) begin
      tok_step_q.delete();
      add_tok(r0.kind, r0.word_byte, r0.op);
      if (n > 2'd1) add_tok(r1.kind, r1.word_byte, r1.op);
      if (n > 2'd2) add_tok(r2.kind, r2.word_byte, r2.op);
    end
    if (tok_step_q.size() != 0) begin
      t = tok_step_q[tok_step_q.size() - 1];
      t.last = 1'b1;
      tok_step_q[tok_step_q.size() - 1] = t;
    end
    tok_q = {tok_q, tok_step_q};
    tok_step_q.delete();
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(negedge clk_i);
    while (tok_q.size() != 0) @(negedge clk_i);
  endtask

  initial begin
    int         n_sent;
    int         line_len;
    logic [7:0] ch;
    n_err         = 0;
    idle_on       = 1'b1;
    in_squote     = 1'b0;
    in_dquote     = 1'b0;
    esc_next      = 1'b0;
    word_open     = 1'b0;
    held_op       = PEND_NONE;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = 8'h00;
    s_axis_tlast  = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    for (int i = 0; i < DirLen; i++) begin
      put_char(dir_tab[i].ch, dir_tab[i].eol, dir_tab[i].n,
               dir_tab[i].r0, dir_tab[i].r1, dir_tab[i].r2);
    end
    wait_drained();

    // Lines built half from the characters the lexer cares about, with
    // lowercase letters and arbitrary bytes for the rest.
    n_sent = 0;
    while (n_sent < RandItems) begin
      line_len = $urandom_range(1, 12);
      for (int k = 0; k < line_len; k++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: ch = special_chars[$urandom_range(0, 7)];
          5, 6, 7:       ch = 8'h61 + 8'($urandom_range(0, 25));
          default:       ch = 8'($urandom_range(0, 255));
        endcase
        put_char(ch, k == line_len - 1, 2'd0, RES_NONE, RES_NONE, RES_NONE);
        n_sent++;
        if (n_sent == RandItems / 2) wait_drained();
        if (n_sent == RandItems - CalmItems) idle_on = 1'b0;
      end
    end

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (n_err == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(negedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(negedge clk_i);
    end
  end

  task automatic check_field(input string name, input int exp_val, input int act_val);
    if (exp_val != act_val) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
      n_err++;
    end
  endtask

  always @(posedge clk_i) begin
    tok_t t;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (tok_q.size() == 0) begin
        $error("unexpected result transaction: kind %0d tdata %h", m_axis_tuser, m_axis_tdata);
        n_err++;
      end else begin
        t = tok_q.pop_front();
        check_field("item_kind", t.r.kind, m_axis_tuser);
        check_field("word_byte", t.r.word_byte, m_axis_tdata[7:0]);
        check_field("operator_code", t.r.op, m_axis_tdata[10:8]);
        check_field("run_last", t.last, m_axis_tlast);
        check_field("tdata padding", 0, m_axis_tdata[15:11]);
      end
    end
  end

endmodule

// ===== files.f =====
design/shcl_pkg.sv
design/shell_command_line_lexer.sv
verif/shell_command_line_lexer_tb.sv
